// ===== hw/rtl/mtg_pkg.sv =====
// Package for the MT19937 generator: table sizes, recurrence constants,
// the twist mix and the tempering functions. No dependencies.
package mtg_pkg;

  localparam int unsigned TblLen = 624;
  localparam int unsigned TblMid = 397;
  localparam int unsigned IdxW   = 10;

  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] TwistXor    = 32'h9908_b0df;
  localparam logic [31:0] HiBit       = 32'h8000_0000;
  localparam logic [31:0] LoBits      = 32'h7fff_ffff;
  localparam logic [31:0] TemperB     = 32'h9d2c_5680;
  localparam logic [31:0] TemperC     = 32'hefc6_0000;

  // control from the sequencer to the seeding unit
  typedef struct packed {
    logic load;  // take the seed as table word 0
    logic adv;   // move on to the next table word
  } seed_ctrl_t;

  // seeding unit status
  typedef struct packed {
    logic [31:0] word;  // table word to push into the chain
    logic        last;  // word is the final table entry
  } seed_stat_t;

  function automatic logic [31:0] mix_word(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = (a & HiBit) | (b & LoBits);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TwistXor;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mersenne_twister_generator.sv =====
// MT19937 generator top level: sequencer, seed register, 624-cell state
// chain and output register. Uses mtg_pkg, mtg_cell and mtg_seeder.
//
// Usage: each item on the request channel (in_valid_i/in_ready_o, field
// restart_i) yields one tempered 32-bit word on the result channel
// (out_valid_o/out_ready_i, field word_o). The seed register is written
// through cfg_we_i/cfg_wdata_i and only takes effect at the next seeding.
// The state is a ring of 624 word cells; each result shifts the ring by one
// word and pushes in the twisted word computed from cells 0, 1 and 397.
// An item that needs no seeding has its word registered in the output register in the
// next cycle, and one item per cycle is sustained while the receiver takes each word.
// The first item after reset and any item with restart_i set first push 624 seed words
// through the ring, one per cycle from the seed multiplier, and its word is produced
// in StStep once the output register is free; no item is accepted meanwhile.
// Reset: seed returns to 5489 and the ring is marked unseeded.
// When the receiver stalls the word waits in the output register and
// in_ready_o drops until it is taken.
module mersenne_twister_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] word_o
);
  import mtg_pkg::*;

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StSeed = 2'd1;
  localparam logic [1:0] StStep = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        seeded_q, seeded_d;
  logic [31:0] seed_q, seed_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;

  logic        out_free;
  logic        in_acc;
  logic        shift;
  logic        produce;
  logic [31:0] push_word;
  logic [31:0] mix_w;

  seed_ctrl_t  sctrl;
  seed_stat_t  sstat;

  logic [31:0] ring [TblLen];

  mtg_seeder u_seeder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sctrl),
    .seed_i (seed_q),
    .stat_o (sstat)
  );

  assign mix_w     = mix_word(ring[0], ring[1], ring[TblMid]);
  assign push_word = (state_q == StSeed) ? sstat.word : mix_w;

  for (genvar i = 0; i < TblLen; i++) begin : g_ring
    if (i == TblLen - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .data_i  (push_word),
        .data_o  (ring[i])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .data_i  (ring[i+1]),
        .data_o  (ring[i])
      );
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StRun) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    seeded_d   = seeded_q;
    sctrl.load = 1'b0;
    sctrl.adv  = 1'b0;
    shift      = 1'b0;
    produce    = 1'b0;
    unique case (state_q)
      StRun: begin
        if (in_acc) begin
          if (restart_i || !seeded_q) begin
            sctrl.load = 1'b1;
            seeded_d   = 1'b1;
            state_d    = StSeed;
          end else begin
            shift   = 1'b1;
            produce = 1'b1;
          end
        end
      end
      StSeed: begin
        shift     = 1'b1;
        sctrl.adv = 1'b1;
        if (sstat.last) begin
          state_d = StStep;
        end
      end
      StStep: begin
        if (out_free) begin
          shift   = 1'b1;
          produce = 1'b1;
          state_d = StRun;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    word_d      = word_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (produce) begin
      out_valid_d = 1'b1;
      word_d      = temper(mix_w);
    end
  end

  assign seed_d = cfg_we_i ? cfg_wdata_i : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      seeded_q    <= 1'b0;
      seed_q      <= DefaultSeed;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;

endmodule

// ===== hw/rtl/mtg_cell.sv =====
// One 32-bit word of the MT19937 state chain.
// Takes its neighbour's word whenever the chain shifts. No package needed.
module mtg_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] data_i,
  output logic [31:0] data_o
);

  logic [31:0] data_q;
  logic [31:0] data_d;

  assign data_d = shift_i ? data_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/mtg_seeder.sv =====
// Seeding unit: produces the initial table words one per cycle while ctrl_i.adv is set, from the
// seed, t[i] = 1812433253 * (t[i-1] ^ (t[i-1] >> 30)) + i. Uses mtg_pkg.
module mtg_seeder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtg_pkg::seed_ctrl_t ctrl_i,
  input  logic [31:0]        seed_i,
  output mtg_pkg::seed_stat_t stat_o
);
  import mtg_pkg::*;

  logic [31:0]     gen_q, gen_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     folded;
  logic [31:0]     prod;
  logic [31:0]     nxt;

  // only the low word of the product is kept (mod 2^32)
  assign folded = gen_q ^ (gen_q >> 30);
  assign prod   = SeedMult * folded;
  assign nxt    = prod + {{(32-IdxW){1'b0}}, idx_q};

  always_comb begin
    gen_d = gen_q;
    idx_d = idx_q;
    if (ctrl_i.load) begin
      gen_d = seed_i;
      idx_d = IdxW'(1);
    end else if (ctrl_i.adv) begin
      gen_d = nxt;
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q <= gen_d;
  end

  assign stat_o.word = gen_q;
  assign stat_o.last = (idx_q == IdxW'(TblLen));

endmodule

// ===== hw/rtl/mtg_checker.sv =====
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on mersenne_twister_generator only through its ports.
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        restart_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] word_o
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_o))
    else $error("stalled result item changed");

  // a new item is only taken when the output register is free
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_ready_i)
    else $error("request taken while result blocked");

  // a restart item blocks the request channel while the ring is reseeded
  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && restart_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during reseeding");

  // an item taken without restart_i while a result is shown gives a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !restart_i && out_valid_o |=> out_valid_o)
    else $error("result missing after accepted item");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .restart_i   (restart_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .word_o      (word_o)
);
